FILE: hdl/aperture_disk_smearing_core_defines.svh
// Assertion helpers for the aperture disk smearing core.
`ifndef APERTURE_DISK_SMEARING_CORE_DEFINES_SVH
`define APERTURE_DISK_SMEARING_CORE_DEFINES_SVH

// Clocked assertion, disabled during reset.
`define ADSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication form: antecedent |-> consequent.
`define ADSC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/adsc_pkg.sv
package adsc_pkg;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int MAX_HALF    = 15;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int DIM_W       = 9;
   localparam int POS_W       = 8;
   localparam int HALF_W      = 4;
   localparam int OFS_W       = HALF_W + 2;
   localparam int COMP_W      = 32;
   localparam int TDATA_W     = 40;
   localparam int PADDR_W     = 5;
   localparam int PDATA_W     = 32;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_SPACING_COL  = 3'd2,
      REG_SPACING_ROW  = 3'd3,
      REG_SMEAR_RADIUS = 3'd4
   } reg_index_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EMIT = 1'b1;
endpackage

FILE: hdl/aperture_disk_smearing_core.sv
// Load word: written straight into the frame store.
// Emit word: walks the (2*half_row+1) x (2*half_col+1) window, one offset per cycle
// through a 4-stage test/read pipeline.
// A configuration write recomputes the half-sizes, no words taken then.
// Synchronous active-high reset initialises counts, configuration registers and control; the frame
// store is not cleared and holds whatever was last loaded.
`include "aperture_disk_smearing_core_defines.svh"

module aperture_disk_smearing_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [adsc_pkg::TDATA_W-1:0]    req_tdata,  // aperture_bit, comp_value[32:1], pad
   input  logic                            req_tuser,  // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [adsc_pkg::TDATA_W-1:0]    rsp_tdata,  // aperture_out, comp_out[32:1], pad
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [adsc_pkg::PADDR_W-1:0]    csr_paddr,
   input  logic [adsc_pkg::PDATA_W-1:0]    csr_pwdata,
   output logic [adsc_pkg::PDATA_W-1:0]    csr_prdata,
   output logic                            csr_pready
);
   import adsc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_HALF, ST_WALK, ST_DONE} state_type;

   state_type             state_ff;
   logic [DIM_W-1:0]      width_ff, height_ff;
   logic [15:0]           spc_col_ff, spc_row_ff, radius_ff;
   logic [31:0]           rr_ff;
   logic [HALF_W-1:0]     half_col_ff, half_row_ff, k_ff;
   logic [CNT_W-1:0]      load_count_ff, emit_count_ff;
   logic [POS_W-1:0]      row_ff, col_ff;
   logic                  gen_act_ff;
   logic signed [OFS_W-1:0] dr_ff, dc_ff;
   logic                  s1_v_ff, s1_in_ff, s2_v_ff, s2_in_ff, rd_v_ff;
   logic [ADDR_W-1:0]     s1_addr_ff, s2_addr_ff;
   logic [19:0]           s1_ry_ff, s1_rx_ff;
   logic [39:0]           s2_ry2_ff, s2_rx2_ff;
   logic [COMP_W:0]       rdata_ff;
   logic                  ap_acc_ff;
   logic [COMP_W-1:0]     min_acc_ff;
   logic                  rsp_v_ff, rsp_last_ff, rsp_ap_ff;
   logic [COMP_W-1:0]     rsp_comp_ff;

   logic [COMP_W:0] store_mem [STORE_DEPTH];

   logic [DIM_W-1:0]   w_eff, h_eff;
   logic [CNT_W-1:0]   total;
   logic               cfg_wr, req_acc, pass, pipe_empty, out_free, frame_end;
   logic signed [10:0] pr, pc;
   logic               in_frame;
   logic [16:0]        addr_full;
   logic [HALF_W-1:0]  abs_dr, abs_dc;
   logic [4:0]         odd_k;
   logic [20:0]        term_c, term_r;
   logic [20:0]        two_r;
   logic               zero_case_c, zero_case_r;
   logic [40:0]        dist2;
   logic [COMP_W-1:0]  v_biased;
   logic signed [OFS_W-1:0] neg_hr, neg_hc;

   always_comb begin
      w_eff = (width_ff == '0) ? DIM_W'(1) :
              (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
      h_eff = (height_ff == '0) ? DIM_W'(1) :
              (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;
   end
   assign total = CNT_W'(w_eff * h_eff);

   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   always_comb begin
      case (reg_index_type'(csr_paddr[4:2]))
         REG_IMAGE_WIDTH:  csr_prdata = PDATA_W'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = PDATA_W'(height_ff);
         REG_SPACING_COL:  csr_prdata = PDATA_W'(spc_col_ff);
         REG_SPACING_ROW:  csr_prdata = PDATA_W'(spc_row_ff);
         REG_SMEAR_RADIUS: csr_prdata = PDATA_W'(radius_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;

   // half-size: count k in 1..MAX_HALF with (2k-1)*spacing <= 2*radius
   assign odd_k  = {k_ff, 1'b0} - 5'd1;
   assign term_c = odd_k * spc_col_ff;
   assign term_r = odd_k * spc_row_ff;
   assign two_r  = {4'b0, radius_ff, 1'b0};
   assign zero_case_c = (spc_col_ff == '0) && (radius_ff == '0);
   assign zero_case_r = (spc_row_ff == '0) && (radius_ff == '0);

   // window generator
   assign pr = $signed({3'b000, row_ff}) + 11'(dr_ff);
   assign pc = $signed({3'b000, col_ff}) + 11'(dc_ff);
   assign in_frame = (pr >= 0) && (pr < $signed({2'b00, h_eff})) &&
                     (pc >= 0) && (pc < $signed({2'b00, w_eff}));
   assign addr_full = 17'(pr[POS_W-1:0] * w_eff) + 17'(pc[POS_W-1:0]);
   assign abs_dr = dr_ff[OFS_W-1] ? HALF_W'(-dr_ff) : HALF_W'(dr_ff);
   assign abs_dc = dc_ff[OFS_W-1] ? HALF_W'(-dc_ff) : HALF_W'(dc_ff);
   assign neg_hr = -$signed({2'b00, half_row_ff});
   assign neg_hc = -$signed({2'b00, half_col_ff});

   assign dist2 = {1'b0, s2_ry2_ff} + {1'b0, s2_rx2_ff};
   assign pass  = s2_v_ff && s2_in_ff && (dist2 <= {9'b0, rr_ff});
   assign v_biased = rdata_ff[COMP_W:1] ^ {1'b1, {(COMP_W-1){1'b0}}};
   assign pipe_empty = !gen_act_ff && !s1_v_ff && !s2_v_ff && !rd_v_ff;
   assign out_free   = !rsp_v_ff || rsp_tready;
   assign frame_end  = (emit_count_ff + CNT_W'(1)) >= total;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_ff      <= DIM_W'(1);
         height_ff     <= DIM_W'(1);
         spc_col_ff    <= 16'd256;
         spc_row_ff    <= 16'd256;
         radius_ff     <= '0;
         rr_ff         <= '0;
         half_col_ff   <= '0;
         half_row_ff   <= '0;
         k_ff          <= '0;
         load_count_ff <= '0;
         emit_count_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         gen_act_ff    <= 1'b0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rd_v_ff       <= 1'b0;
         rsp_v_ff      <= 1'b0;
      end else begin
         s1_v_ff <= gen_act_ff;
         s2_v_ff <= s1_v_ff;
         rd_v_ff <= pass;
         rr_ff   <= radius_ff * radius_ff;
         if (rsp_v_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_v_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_tuser == REQ_LOAD && load_count_ff < total) begin
                  load_count_ff <= load_count_ff + CNT_W'(1);
               end
               if (req_acc && req_tuser == REQ_EMIT) begin
                  gen_act_ff <= 1'b1;
                  dr_ff      <= neg_hr;
                  dc_ff      <= neg_hc;
                  state_ff   <= ST_WALK;
               end
            end
            ST_HALF: begin
               if (term_c <= two_r && !zero_case_c) begin
                  half_col_ff <= half_col_ff + HALF_W'(1);
               end
               if (term_r <= two_r && !zero_case_r) begin
                  half_row_ff <= half_row_ff + HALF_W'(1);
               end
               k_ff <= k_ff + HALF_W'(1);
               if (k_ff == HALF_W'(MAX_HALF)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WALK: begin
               if (gen_act_ff) begin
                  if (dc_ff == $signed({2'b00, half_col_ff})) begin
                     dc_ff <= neg_hc;
                     if (dr_ff == $signed({2'b00, half_row_ff})) begin
                        gen_act_ff <= 1'b0;
                     end else begin
                        dr_ff <= dr_ff + OFS_W'(1);
                     end
                  end else begin
                     dc_ff <= dc_ff + OFS_W'(1);
                  end
               end else if (pipe_empty) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_v_ff <= 1'b1;
                  state_ff <= ST_IDLE;
                  if (frame_end) begin
                     emit_count_ff <= '0;
                     load_count_ff <= '0;
                     row_ff        <= '0;
                     col_ff        <= '0;
                  end else begin
                     emit_count_ff <= emit_count_ff + CNT_W'(1);
                     if (DIM_W'(col_ff) + DIM_W'(1) >= w_eff) begin
                        col_ff <= '0;
                        row_ff <= row_ff + POS_W'(1);
                     end else begin
                        col_ff <= col_ff + POS_W'(1);
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (cfg_wr && csr_paddr[4:2] <= REG_SMEAR_RADIUS) begin
            case (reg_index_type'(csr_paddr[4:2]))
               REG_IMAGE_WIDTH:  width_ff   <= csr_pwdata[DIM_W-1:0];
               REG_IMAGE_HEIGHT: height_ff  <= csr_pwdata[DIM_W-1:0];
               REG_SPACING_COL:  spc_col_ff <= csr_pwdata[15:0];
               REG_SPACING_ROW:  spc_row_ff <= csr_pwdata[15:0];
               REG_SMEAR_RADIUS: radius_ff  <= csr_pwdata[15:0];
               default:          radius_ff  <= radius_ff;
            endcase
            if (csr_paddr[4:2] == REG_IMAGE_WIDTH || csr_paddr[4:2] == REG_IMAGE_HEIGHT) begin
               load_count_ff <= '0;
               emit_count_ff <= '0;
               row_ff        <= '0;
               col_ff        <= '0;
            end
            half_col_ff <= '0;
            half_row_ff <= '0;
            k_ff        <= HALF_W'(1);
            state_ff    <= ST_HALF;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s1_in_ff   <= in_frame;
      s1_addr_ff <= addr_full[ADDR_W-1:0];
      s1_ry_ff   <= abs_dr * spc_row_ff;
      s1_rx_ff   <= abs_dc * spc_col_ff;
      s2_in_ff   <= s1_in_ff;
      s2_addr_ff <= s1_addr_ff;
      s2_ry2_ff  <= s1_ry_ff * s1_ry_ff;
      s2_rx2_ff  <= s1_rx_ff * s1_rx_ff;
      if (state_ff == ST_IDLE) begin
         ap_acc_ff  <= 1'b0;
         min_acc_ff <= '1;
      end else if (rd_v_ff) begin
         ap_acc_ff <= ap_acc_ff | rdata_ff[0];
         if (v_biased < min_acc_ff) begin
            min_acc_ff <= v_biased;
         end
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_ap_ff   <= ap_acc_ff;
         rsp_comp_ff <= min_acc_ff ^ {1'b1, {(COMP_W-1){1'b0}}};
         rsp_last_ff <= frame_end;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (req_acc && req_tuser == REQ_LOAD && load_count_ff < total) begin
         store_mem[load_count_ff[ADDR_W-1:0]] <= {req_tdata[COMP_W:1], req_tdata[0]};
      end
      if (pass) begin
         rdata_ff <= store_mem[s2_addr_ff];
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {{(TDATA_W-COMP_W-1){1'b0}}, rsp_comp_ff, rsp_ap_ff};
   assign rsp_tlast  = rsp_last_ff;

   `ADSC_ASSERT(a_load_bound, clock, reset, load_count_ff <= total, "load count past frame")
   `ADSC_ASSERT(a_emit_bound, clock, reset, emit_count_ff < total, "emit count past frame")
   `ADSC_ASSERT_IMP(a_rd_walk, clock, reset, rd_v_ff, state_ff == ST_WALK, "read outside walk")
   `ADSC_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_v_ff), $past(state_ff) == ST_DONE, "result without walk")
   `ADSC_ASSERT_IMP(a_gen_half, clock, reset, gen_act_ff && state_ff == ST_WALK, dr_ff <= $signed({2'b00, half_row_ff}), "row offset beyond half-size")

endmodule
